>>> design/smc_pkg.sv
`timescale 1ns / 1ps
package smc_pkg;

	// Fixed field widths of the channels.
	localparam int WIDX_W   = 9;
	localparam int DATA_W   = 16;
	localparam int SUM_W    = 38;
	localparam int PROD_W   = 32;
	localparam int POS_W    = 16;
	localparam int CNT_W    = 3;
	localparam int CFG_W    = 4;
	localparam int CIDX_W   = 3;
	localparam int WDEPTH   = 512;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] REG_STRIDE  = 3'd0;
	localparam logic [CIDX_W-1:0] REG_TAPS    = 3'd1;
	localparam logic [CIDX_W-1:0] REG_CHANS   = 3'd2;
	localparam logic [CIDX_W-1:0] REG_KERNELS = 3'd3;

	// Item actions.
	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// Control of the shared multiply-accumulate unit.
	typedef struct packed {
		logic clr;
		logic issue;
	} mac_ctl_t;

	// A register value of zero counts as one; values above the cap count as the cap.
	function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
		input logic [CFG_W-1:0] cap);
		logic [CFG_W-1:0] r;
		r = v;
		if (v == '0) r = 4'd1;
		else if (v > cap) r = cap;
		return r;
	endfunction

endpackage

>>> design/smc_if.sv
`timescale 1ns / 1ps
interface smc_in_if;
	logic                                valid;
	logic                                ready;
	logic                                action;
	logic [smc_pkg::WIDX_W-1:0]          weight_index;
	logic signed [smc_pkg::DATA_W-1:0]   weight_value;
	logic signed [smc_pkg::DATA_W-1:0]   sample;
	logic                                end_of_sequence;
	modport source (output valid, action, weight_index, weight_value, sample,
		end_of_sequence, input ready);
	modport sink (input valid, action, weight_index, weight_value, sample,
		end_of_sequence, output ready);
endinterface

interface smc_out_if;
	logic                                valid;
	logic                                ready;
	logic [smc_pkg::CNT_W-1:0]           kernel_index;
	logic [smc_pkg::POS_W-1:0]           out_position;
	logic signed [smc_pkg::SUM_W-1:0]    conv_sum;
	logic                                last_of_run;
	modport source (output valid, kernel_index, out_position, conv_sum, last_of_run,
		input ready);
	modport sink (input valid, kernel_index, out_position, conv_sum, last_of_run,
		output ready);
endinterface

interface smc_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [smc_pkg::CIDX_W-1:0]          index;
	logic [smc_pkg::CFG_W-1:0]           data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> design/smc_ram.sv
`timescale 1ns / 1ps
module smc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                  wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                  rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> design/smc_mac.sv
`timescale 1ns / 1ps
module smc_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  smc_pkg::mac_ctl_t                   ctl,
	input  logic signed [smc_pkg::DATA_W-1:0]   sample_s1,
	input  logic signed [smc_pkg::DATA_W-1:0]   weight_s1,
	output logic                                busy,
	output logic signed [smc_pkg::SUM_W-1:0]    acc
);
	logic                                  v_s1;
	logic                                  v_s2;
	logic signed [smc_pkg::PROD_W-1:0]     prod_s2;
	logic signed [smc_pkg::SUM_W-1:0]      acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= sample_s1 * weight_s1;
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + smc_pkg::SUM_W'(prod_s2);
		end
	end

	assign busy = v_s1 | v_s2;
	assign acc  = acc_q;
endmodule

>>> design/strided_multichannel_conv1d.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake      Carries
// in_ch     in   valid/ready    action, weight_index, weight_value, sample, end_of_sequence
// out_ch    out  valid/ready    kernel_index, out_position, conv_sum, last_of_run
// cfg_ch    in   valid/ready    index, data (stride, taps, channels, kernels)
//
// A weight load or a sample that closes no window leaves the block idle and the input ready.
// A sample that closes a window holds the input not ready until every kernel's sum is loaded.
// The single multiply-accumulate unit does one product per cycle, then drains its pipeline,
// and the sum is loaded into the output register, for every kernel.
// Reset clears the sequence counters and sets stride 1, three taps, one channel and one kernel; stores start undefined.
// A stalled output holds the sequencer in its emit state; configuration is always ready.
module strided_multichannel_conv1d #(
	parameter int MAX_TAPS     = 8,
	parameter int MAX_CHANNELS = 8,
	parameter int MAX_KERNELS  = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	smc_in_if.sink     in_ch,
	smc_out_if.source  out_ch,
	smc_cfg_if.sink    cfg_ch
);
	localparam int SLOT_W  = MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1;
	localparam int WIN_D   = MAX_TAPS * MAX_CHANNELS;
	localparam int WADDR_W = $clog2(WIN_D > 1 ? WIN_D : 2);
	localparam logic [smc_pkg::CFG_W-1:0] TAP_CAP  = smc_pkg::CFG_W'(MAX_TAPS < 8 ? MAX_TAPS : 8);
	localparam logic [smc_pkg::CFG_W-1:0] CHAN_CAP =
		smc_pkg::CFG_W'(MAX_CHANNELS < 8 ? MAX_CHANNELS : 8);
	localparam logic [smc_pkg::CFG_W-1:0] KERN_CAP =
		smc_pkg::CFG_W'(MAX_KERNELS < 8 ? MAX_KERNELS : 8);
	localparam logic [smc_pkg::CFG_W-1:0] STRIDE_CAP = 4'd8;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_TAPS - 1);

	// Configuration registers, kept as written.
	logic [smc_pkg::CFG_W-1:0] stride_q, taps_q, chans_q, kerns_q;
	logic [smc_pkg::CFG_W-1:0] stride, taps, chans, kerns;

	assign stride = smc_pkg::clamp_cfg(stride_q, STRIDE_CAP);
	assign taps   = smc_pkg::clamp_cfg(taps_q, TAP_CAP);
	assign chans  = smc_pkg::clamp_cfg(chans_q, CHAN_CAP);
	assign kerns  = smc_pkg::clamp_cfg(kerns_q, KERN_CAP);

	// Sequence tracking.
	logic [smc_pkg::POS_W-1:0] pos_q, oidx_q;
	logic [smc_pkg::CNT_W-1:0] chn_q, phase_q;
	logic                      primed_q;
	logic [SLOT_W-1:0]         ring_q;

	// Sequencer.
	smc_pkg::state_t state_q, state_n;
	logic [smc_pkg::CNT_W-1:0] k_q, t_q, c_q;
	logic [SLOT_W-1:0]         slot_q, base_q;
	logic [smc_pkg::POS_W-1:0] tag_q;

	// Output register.
	logic                              out_valid_q;
	logic [smc_pkg::CNT_W-1:0]         out_k_q;
	logic [smc_pkg::POS_W-1:0]         out_pos_q;
	logic signed [smc_pkg::SUM_W-1:0]  out_sum_q;
	logic                              out_last_q;

	logic in_acc, cfg_acc, ld_acc, smp_acc;
	logic restart;

	assign in_ch.ready  = (state_q == smc_pkg::ST_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign in_acc  = in_ch.valid & in_ch.ready;
	assign cfg_acc = cfg_ch.valid & cfg_ch.ready;
	assign ld_acc  = in_acc & (in_ch.action == smc_pkg::ACT_LOAD);
	assign smp_acc = in_acc & (in_ch.action == smc_pkg::ACT_SAMPLE);

	// The sample's channel slot; a count past the configured channels sticks at the last.
	logic [smc_pkg::CNT_W-1:0] ch_eff;
	logic                      last_ch;
	logic                      primed_n;
	logic [smc_pkg::CNT_W-1:0] phase_eff;
	logic [smc_pkg::CFG_W-1:0] phase_inc;
	logic                      emit;
	logic [SLOT_W:0]           start_sum;
	logic [SLOT_W-1:0]         start_slot;
	logic [WADDR_W-1:0]        win_waddr, win_raddr;

	always_comb begin
		ch_eff = chn_q;
		if ({1'b0, chn_q} >= chans) ch_eff = smc_pkg::CNT_W'(chans - 4'd1);
		last_ch   = ({1'b0, ch_eff} + 4'd1) >= chans;
		primed_n  = primed_q | (({1'b0, pos_q} + 17'd1) >= {13'd0, taps});
		phase_eff = (primed_q) ? phase_q : '0;
		phase_inc = {1'b0, phase_eff} + 4'd1;
		emit      = smp_acc & last_ch & primed_n & (phase_eff == '0);
		// Oldest ring slot of the window that ends at the current slot.
		start_sum = {1'b0, ring_q} + (SLOT_W + 1)'(MAX_TAPS) - (SLOT_W + 1)'(taps - 4'd1);
		if (start_sum >= (SLOT_W + 1)'(MAX_TAPS)) begin
			start_sum = start_sum - (SLOT_W + 1)'(MAX_TAPS);
		end
		start_slot = start_sum[SLOT_W-1:0];
		win_waddr  = WADDR_W'(int'(ring_q) * MAX_CHANNELS + int'(ch_eff));
		win_raddr  = WADDR_W'(int'(slot_q) * MAX_CHANNELS + int'(c_q));
	end

	assign restart = cfg_acc | (smp_acc & in_ch.end_of_sequence);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= 4'd1;
			taps_q   <= 4'd3;
			chans_q  <= 4'd1;
			kerns_q  <= 4'd1;
		end else if (cfg_acc) begin
			unique case (cfg_ch.index)
				smc_pkg::REG_STRIDE:  stride_q <= cfg_ch.data;
				smc_pkg::REG_TAPS:    taps_q   <= cfg_ch.data;
				smc_pkg::REG_CHANS:   chans_q  <= cfg_ch.data;
				smc_pkg::REG_KERNELS: kerns_q  <= cfg_ch.data;
				default: ;
			endcase
		end
	end

	// A write to an index past the list changes nothing, not even the sequence.
	logic cfg_hit;
	assign cfg_hit = cfg_acc & (cfg_ch.index == smc_pkg::REG_STRIDE ||
		cfg_ch.index == smc_pkg::REG_TAPS || cfg_ch.index == smc_pkg::REG_CHANS ||
		cfg_ch.index == smc_pkg::REG_KERNELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			oidx_q   <= '0;
			chn_q    <= '0;
			phase_q  <= '0;
			primed_q <= 1'b0;
			ring_q   <= '0;
		end else if (cfg_hit || (restart && !cfg_acc)) begin
			pos_q    <= '0;
			oidx_q   <= '0;
			chn_q    <= '0;
			phase_q  <= '0;
			primed_q <= 1'b0;
			ring_q   <= '0;
		end else if (smp_acc) begin
			if (!last_ch) begin
				chn_q <= ch_eff + 3'd1;
			end else begin
				chn_q    <= '0;
				primed_q <= primed_n;
				if (primed_n) begin
					phase_q <= (phase_inc >= stride) ? '0 : phase_inc[smc_pkg::CNT_W-1:0];
				end
				if (emit) oidx_q <= oidx_q + 16'd1;
				pos_q  <= pos_q + 16'd1;
				ring_q <= (ring_q == SLOT_LAST) ? '0 : ring_q + SLOT_W'(1);
			end
		end
	end

	// Stores.
	logic [smc_pkg::DATA_W-1:0] win_rdata, wgt_rdata;
	logic [smc_pkg::WIDX_W-1:0] wgt_raddr;

	assign wgt_raddr = {t_q, c_q, k_q};

	smc_ram #(.WIDTH(smc_pkg::DATA_W), .DEPTH(WIN_D)) u_window (
		.clk   (clk),
		.we    (smp_acc),
		.waddr (win_waddr),
		.wdata (in_ch.sample),
		.raddr (win_raddr),
		.rdata (win_rdata)
	);

	smc_ram #(.WIDTH(smc_pkg::DATA_W), .DEPTH(smc_pkg::WDEPTH)) u_weight (
		.clk   (clk),
		.we    (ld_acc),
		.waddr (in_ch.weight_index),
		.wdata (in_ch.weight_value),
		.raddr (wgt_raddr),
		.rdata (wgt_rdata)
	);

	// Shared multiply-accumulate unit.
	smc_pkg::mac_ctl_t mac_ctl;
	logic mac_busy;
	logic signed [smc_pkg::SUM_W-1:0] mac_acc;

	smc_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mac_ctl),
		.sample_s1 (win_rdata),
		.weight_s1 (wgt_rdata),
		.busy      (mac_busy),
		.acc       (mac_acc)
	);

	logic last_issue, out_load, last_kern;
	assign last_issue = ({1'b0, t_q} + 4'd1 == taps) && ({1'b0, c_q} + 4'd1 == chans);
	assign last_kern  = ({1'b0, k_q} + 4'd1 == kerns);

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			smc_pkg::ST_IDLE:  if (emit) state_n = smc_pkg::ST_MAC;
			smc_pkg::ST_MAC:   if (last_issue) state_n = smc_pkg::ST_DRAIN;
			smc_pkg::ST_DRAIN: if (!mac_busy) state_n = smc_pkg::ST_EMIT;
			smc_pkg::ST_EMIT: begin
				if (out_load) state_n = last_kern ? smc_pkg::ST_IDLE : smc_pkg::ST_MAC;
			end
			default: state_n = smc_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		out_load      = (state_q == smc_pkg::ST_EMIT) && (!out_valid_q || out_ch.ready);
		mac_ctl.issue = (state_q == smc_pkg::ST_MAC);
		mac_ctl.clr   = emit || (out_load && !last_kern);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smc_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			k_q    <= '0;
			t_q    <= '0;
			c_q    <= '0;
			slot_q <= start_slot;
			base_q <= start_slot;
			tag_q  <= oidx_q;
		end else if (state_q == smc_pkg::ST_MAC) begin
			if ({1'b0, c_q} + 4'd1 == chans) begin
				c_q    <= '0;
				t_q    <= t_q + 3'd1;
				slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
			end else begin
				c_q <= c_q + 3'd1;
			end
		end else if (out_load && !last_kern) begin
			k_q    <= k_q + 3'd1;
			t_q    <= '0;
			c_q    <= '0;
			slot_q <= base_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_k_q    <= k_q;
			out_pos_q  <= tag_q;
			out_sum_q  <= mac_acc;
			out_last_q <= last_kern;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.kernel_index = out_k_q;
	assign out_ch.out_position = out_pos_q;
	assign out_ch.conv_sum     = out_sum_q;
	assign out_ch.last_of_run  = out_last_q;

	// The multiply pipeline is never active while the block waits for an item.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smc_pkg::ST_IDLE) |-> !mac_busy)
		else $error("multiply pipeline active while idle");

	// A sum is taken only after every product has reached the accumulator.
	a_emit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smc_pkg::ST_EMIT) |-> !mac_busy)
		else $error("sum emitted before pipeline drained");

	// The final result of a run belongs to the last configured kernel.
	a_last_kernel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.last_of_run) |->
		({1'b0, out_ch.kernel_index} + 4'd1 == kerns))
		else $error("last_of_run on wrong kernel");
endmodule

>>> sim/strided_multichannel_conv1d_tb.sv
`timescale 1ns / 1ps
module strided_multichannel_conv1d_tb;

	// One input item as the testbench queues it for the driver.
	typedef struct {
		logic                              action;
		logic [smc_pkg::WIDX_W-1:0]        widx;
		logic signed [smc_pkg::DATA_W-1:0] wval;
		logic signed [smc_pkg::DATA_W-1:0] samp;
		logic                              eos;
	} conv_item_t;

	// One sum that the block must produce, in the order it must come out.
	typedef struct {
		logic [smc_pkg::CNT_W-1:0]        kidx;
		logic [smc_pkg::POS_W-1:0]        opos;
		logic signed [smc_pkg::SUM_W-1:0] sum;
		logic                             last;
	} conv_sum_t;

	// Longest wait for the multiply-accumulate unit to finish one window
	// at the largest configuration, with some margin.
	localparam int DRAIN_CYCLES = 700;

	logic clk = 1'b0;
	logic arst_n;

	smc_in_if  in_if ();
	smc_out_if out_if ();
	smc_cfg_if cfg_if ();

	strided_multichannel_conv1d uut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_if.sink),
		.out_ch(out_if.source),
		.cfg_ch(cfg_if.sink)
	);

	always #1 clk = ~clk;

	conv_item_t  item_q[$];
	conv_sum_t   pending_sums[$];
	int          err_count = 0;
	int          item_count = 0;
	bit          weight_loaded[smc_pkg::WDEPTH];

	// The predictor's own copy of the block's state and registers.
	logic [smc_pkg::DATA_W-1:0] win_mem[64];
	logic [smc_pkg::DATA_W-1:0] wt_mem[smc_pkg::WDEPTH];
	logic [smc_pkg::POS_W-1:0]  pos_cnt;
	int                         chan_now;
	int                         phase_now;
	bit                         window_full;
	logic [smc_pkg::POS_W-1:0]  win_index;
	int                         ring_pos;
	logic [smc_pkg::CFG_W-1:0]  cfg_regs[4];

	function automatic int clamp_reg(logic [smc_pkg::CFG_W-1:0] v, int cap);
		if (v == 0) return 1;
		if (v > cap) return cap;
		return v;
	endfunction

	// A register write restarts the sequence, as does an end-of-sequence sample.
	function automatic void restart_counting();
		pos_cnt = '0;
		chan_now = 0;
		phase_now = 0;
		window_full = 0;
		win_index = '0;
		ring_pos = 0;
	endfunction

	// Works out the sums that one accepted item causes and queues them.
	function automatic void predict_item(conv_item_t it);
		int stride, taps, chans, kerns, ch, slot;
		longint acc;
		conv_sum_t r;
		stride = clamp_reg(cfg_regs[smc_pkg::REG_STRIDE], 8);
		taps   = clamp_reg(cfg_regs[smc_pkg::REG_TAPS], 8);
		chans  = clamp_reg(cfg_regs[smc_pkg::REG_CHANS], 8);
		kerns  = clamp_reg(cfg_regs[smc_pkg::REG_KERNELS], 8);
		if (it.action == smc_pkg::ACT_LOAD) begin
			wt_mem[it.widx] = it.wval;
			return;
		end
		ch = (chan_now >= chans) ? chans - 1 : chan_now;
		win_mem[ring_pos * 8 + ch] = it.samp;
		if (ch + 1 < chans) begin
			chan_now = ch + 1;
		end else begin
			chan_now = 0;
			if (!window_full && int'(pos_cnt) + 1 >= taps) begin
				window_full = 1;
				phase_now = 0;
			end
			if (window_full) begin
				if (phase_now == 0) begin
					for (int k = 0; k < kerns; k++) begin
						acc = 0;
						for (int t = 0; t < taps; t++) begin
							slot = (ring_pos + 8 - (taps - 1 - t)) % 8;
							for (int c = 0; c < chans; c++)
								acc += longint'($signed(win_mem[slot * 8 + c])) *
									longint'($signed(wt_mem[t * 64 + c * 8 + k]));
						end
						r.kidx = smc_pkg::CNT_W'(k);
						r.opos = win_index;
						r.sum  = acc[smc_pkg::SUM_W-1:0];
						r.last = (k + 1 == kerns);
						pending_sums.insert(pending_sums.size(), r);
					end
					win_index = win_index + 16'd1;
				end
				phase_now = phase_now + 1;
				if (phase_now >= stride) phase_now = 0;
			end
			pos_cnt = pos_cnt + 16'd1;
			ring_pos = (ring_pos + 1) % 8;
		end
		if (it.eos) restart_counting();
	endfunction

	// Mostly no gap or a short one, now and then a long stall.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Driver: presents the oldest queued item and holds it until it is taken.
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_if.valid <= 1'b0;
			in_if.action <= smc_pkg::ACT_LOAD;
			in_if.weight_index <= '0;
			in_if.weight_value <= '0;
			in_if.sample <= '0;
			in_if.end_of_sequence <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_if.valid && in_if.ready) begin
				predict_item(item_q.pop_front());
				send_gap = pick_gap();
			end
			if (in_if.valid && !in_if.ready) begin
				// Hold the item until the block takes it.
			end else if (send_gap > 0) begin
				send_gap--;
				in_if.valid <= 1'b0;
			end else if (item_q.size() > 0) begin
				in_if.valid <= 1'b1;
				in_if.action <= item_q[0].action;
				in_if.weight_index <= item_q[0].widx;
				in_if.weight_value <= item_q[0].wval;
				in_if.sample <= item_q[0].samp;
				in_if.end_of_sequence <= item_q[0].eos;
			end else begin
				in_if.valid <= 1'b0;
			end
		end
	end

	// Monitor: stalls the output at random and checks every sum taken.
	int recv_gap;
	always @(posedge clk or negedge arst_n) begin
		conv_sum_t e;
		if (!arst_n) begin
			out_if.ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (out_if.valid && out_if.ready) begin
				if (pending_sums.size() == 0) begin
					$display("%0t: unexpected result: kernel %0d position %0d sum %0d last %0b",
						$time, out_if.kernel_index, out_if.out_position,
						out_if.conv_sum, out_if.last_of_run);
					err_count++;
				end else begin
					e = pending_sums.pop_front();
					if (out_if.kernel_index !== e.kidx) begin
						$display("%0t: kernel_index expected %0d actual %0d",
							$time, e.kidx, out_if.kernel_index);
						err_count++;
					end
					if (out_if.out_position !== e.opos) begin
						$display("%0t: out_position expected %0d actual %0d",
							$time, e.opos, out_if.out_position);
						err_count++;
					end
					if (out_if.conv_sum !== e.sum) begin
						$display("%0t: conv_sum expected %0d actual %0d",
							$time, e.sum, out_if.conv_sum);
						err_count++;
					end
					if (out_if.last_of_run !== e.last) begin
						$display("%0t: last_of_run expected %0b actual %0b",
							$time, e.last, out_if.last_of_run);
						err_count++;
					end
				end
				recv_gap = pick_gap();
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_if.ready <= 1'b0;
			end else begin
				out_if.ready <= 1'b1;
			end
		end
	end

	// Writes one register. The caller lowers valid after its last write, so
	// valid stays high without a drop between back-to-back writes.
	task automatic write_reg(logic [smc_pkg::CIDX_W-1:0] idx, logic [smc_pkg::CFG_W-1:0] val);
		cfg_if.index <= idx;
		cfg_if.data <= val;
		cfg_if.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_regs[idx] = val;
		restart_counting();
	endtask

	// Lets the sender drain and every expected sum arrive, then waits out a
	// window computation that may still be running.
	task automatic wait_idle();
		@(posedge clk);
		while (item_q.size() > 0 || in_if.valid || pending_sums.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void push_load(int addr, logic signed [smc_pkg::DATA_W-1:0] val);
		conv_item_t it;
		it.action = smc_pkg::ACT_LOAD;
		it.widx = smc_pkg::WIDX_W'(addr);
		it.wval = val;
		it.samp = smc_pkg::DATA_W'($urandom());
		it.eos = 1'($urandom_range(0, 1));
		weight_loaded[addr] = 1'b1;
		item_count++;
		item_q.insert(item_q.size(), it);
	endfunction

	function automatic void push_sample(logic signed [smc_pkg::DATA_W-1:0] val, bit eos);
		conv_item_t it;
		it.action = smc_pkg::ACT_SAMPLE;
		it.widx = smc_pkg::WIDX_W'($urandom());
		it.wval = smc_pkg::DATA_W'($urandom());
		it.samp = val;
		it.eos = eos;
		item_count++;
		item_q.insert(item_q.size(), it);
	endfunction

	// Samples and weights, mostly random, sometimes at the extremes of the Q8.8 range.
	function automatic logic signed [smc_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			default: return smc_pkg::DATA_W'($urandom());
		endcase
	endfunction

	// Loads every weight that the given sizes read and that was never written,
	// so no read of an unwritten weight can happen.
	function automatic void cover_weights(int taps, int chans, int kerns);
		for (int t = 0; t < taps; t++)
			for (int c = 0; c < chans; c++)
				for (int k = 0; k < kerns; k++)
					if (!weight_loaded[t * 64 + c * 8 + k])
						push_load(t * 64 + c * 8 + k, pick_value());
	endfunction

	// Queues whole sequences with random content. Most are well formed; some
	// end in the middle of a position or carry a weight load inside.
	task automatic queue_sequences(int nseq, int chans, int max_len);
		int len;
		bit cut;
		for (int s = 0; s < nseq; s++) begin
			len = $urandom_range(1, max_len);
			cut = ($urandom_range(0, 9) == 0) && chans > 1;
			for (int p = 0; p < len; p++) begin
				if ($urandom_range(0, 14) == 0)
					push_load($urandom_range(0, smc_pkg::WDEPTH - 1), pick_value());
				for (int c = 0; c < chans; c++) begin
					if (cut && p == len - 1 && c == chans / 2) begin
						push_sample(pick_value(), 1'b1);
						break;
					end
					push_sample(pick_value(), p == len - 1 && c == chans - 1);
				end
			end
		end
	endtask

	// Writes all four registers, loads the weights the new sizes need, queues the
	// sequences for this setting and waits for the block to go idle.
	task automatic run_setting(logic [smc_pkg::CFG_W-1:0] st, logic [smc_pkg::CFG_W-1:0] tp,
		logic [smc_pkg::CFG_W-1:0] ch, logic [smc_pkg::CFG_W-1:0] kn, int nseq, int max_len);
		write_reg(smc_pkg::REG_STRIDE, st);
		write_reg(smc_pkg::REG_TAPS, tp);
		write_reg(smc_pkg::REG_CHANS, ch);
		write_reg(smc_pkg::REG_KERNELS, kn);
		cfg_if.valid <= 1'b0;
		cover_weights(clamp_reg(tp, 8), clamp_reg(ch, 8), clamp_reg(kn, 8));
		queue_sequences(nseq, clamp_reg(ch, 8), max_len);
		wait_idle();
	endtask

	initial begin
		int tp, ch, kn;
		arst_n = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		cfg_regs[smc_pkg::REG_STRIDE] = 4'd1;
		cfg_regs[smc_pkg::REG_TAPS] = 4'd3;
		cfg_regs[smc_pkg::REG_CHANS] = 4'd1;
		cfg_regs[smc_pkg::REG_KERNELS] = 4'd1;
		restart_counting();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset setting (stride 1, three taps, one
		// channel, one kernel): extreme weights and samples, a weight load
		// in the middle of a sequence, and a restart by end of sequence.
		push_load(0, 16'sh8000);
		push_load(64, 16'sh7fff);
		push_load(128, 16'sh8000);
		push_load(511, 16'sh7fff);
		push_load(256, 16'sh0001);
		push_sample(16'sh8000, 1'b0);
		push_sample(16'sh7fff, 1'b0);
		push_sample(16'sh8000, 1'b0);
		push_sample(16'sh8000, 1'b0);
		push_load(64, 16'sh8000);
		push_sample(16'sh7fff, 1'b0);
		push_sample(16'sh0000, 1'b1);
		push_sample(16'shffff, 1'b0);
		push_sample(16'sh0100, 1'b0);
		push_sample(16'sh8000, 1'b1);
		wait_idle();

		// Smallest setting, then the largest stride, taps and kernel count,
		// then out-of-range values that clamp to one and to eight.
		run_setting(4'd1, 4'd1, 4'd1, 4'd1, 2, 8);
		run_setting(4'd8, 4'd8, 4'd1, 4'd8, 2, 10);
		run_setting(4'd0, 4'd0, 4'd0, 4'd0, 2, 5);
		run_setting(4'd15, 4'd1, 4'd15, 4'd15, 1, 9);
		run_setting(4'd15, 4'd15, 4'd1, 4'd1, 2, 10);
		// Several channels, where a sequence may end in the middle of a position.
		run_setting(4'd2, 4'd2, 4'd4, 4'd3, 3, 6);

		// Random settings, mostly small sizes, until the item budget is spent.
		while (item_count < 320) begin
			tp = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
			ch = $urandom_range(1, 2);
			kn = $urandom_range(1, 2);
			run_setting(smc_pkg::CFG_W'($urandom_range(1, 8)), smc_pkg::CFG_W'(tp),
				smc_pkg::CFG_W'(ch), smc_pkg::CFG_W'(kn), $urandom_range(1, 3), 8);
		end

		if (err_count == 0 && pending_sums.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#10000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
